// ----- src/mdbr_pkg.sv -----
// Shared types, constants and a helper function for the debounce unit.
`timescale 1ns / 1ps

package mdbr_pkg;

    localparam int unsigned MAX_CHANNELS = 16;
    localparam int unsigned DELAY_W      = 5;
    localparam int unsigned COUNT_W      = 8;
    localparam int unsigned CFG_DATA_W   = 40;
    localparam int unsigned CFG_ADDR_W   = 2;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd20;
    localparam logic [DELAY_W-1:0] DELAY_MAX   = 5'd25;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_LOW      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_HIGH     = 2'd2;

    // Item kinds carried in tuser.
    localparam logic ACTION_FAST = 1'b0;
    localparam logic ACTION_SLOW = 1'b1;

    // Per-lane item, common to all lanes.
    typedef struct packed {
        logic                 step;
        logic                 slow;
        logic [COUNT_W-1:0]   limit;
    } t_lane_ctrl;

    // Release load: delay saturated at 25, times ten (8x + 2x).
    function automatic logic [COUNT_W-1:0] f_release_load(input logic [DELAY_W-1:0] delay);
        logic [DELAY_W-1:0] d;
        d = (delay > DELAY_MAX) ? DELAY_MAX : delay;
        return {d, 3'b000} + {2'b00, d, 1'b0};
    endfunction

endpackage

// ----- src/mdbr_lane.sv -----
// One debounce channel: integrating counter, release counter and the two state bits.
`timescale 1ns / 1ps

module mdbr_lane
    import mdbr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctrl         i_ctrl,
    input  logic               i_raw,
    input  logic [COUNT_W-1:0] i_load,
    output logic               o_debounced_next,
    output logic               o_logic_next
);

    logic [COUNT_W-1:0] r_integ, n_integ;
    logic [COUNT_W-1:0] r_rel, n_rel;
    logic               r_deb, n_deb;
    logic               r_logic, n_logic;

    always_comb begin
        n_integ = r_integ;
        n_rel   = r_rel;
        n_deb   = r_deb;
        n_logic = r_logic;
        if (i_ctrl.slow) begin
            if (r_rel != '0) begin
                n_rel = r_rel - 1'b1;
                if (r_rel == COUNT_W'(1)) begin
                    n_logic = 1'b0;
                end
            end
        end else if (i_raw) begin
            // Inactive sample: integrate toward zero, starting the release when zero is reached.
            if (r_integ != '0) begin
                n_integ = r_integ - 1'b1;
                if (r_integ == COUNT_W'(1)) begin
                    n_deb = 1'b0;
                    n_rel = i_load;
                    if (i_load == '0) begin
                        n_logic = 1'b0;
                    end
                end
            end
        end else begin
            if (r_integ < i_ctrl.limit) begin
                n_integ = r_integ + 1'b1;
                if (n_integ == i_ctrl.limit) begin
                    n_deb   = 1'b1;
                    n_logic = 1'b1;
                    n_rel   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_rel   <= '0;
            r_deb   <= 1'b0;
            r_logic <= 1'b0;
        end else if (i_ctrl.step) begin
            r_integ <= n_integ;
            r_rel   <= n_rel;
            r_deb   <= n_deb;
            r_logic <= n_logic;
        end
    end

    assign o_debounced_next = n_deb;
    assign o_logic_next     = n_logic;

    // A set debounced bit always has the logic bit set and no release pending.
    a_deb_logic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_deb |-> r_logic) else $error("debounced bit set without logic bit");
    a_deb_norel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_deb |-> (r_rel == '0)) else $error("release pending while debounced");
    a_rel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel <= COUNT_W'(250)) else $error("release count above maximum load");

endmodule

// ----- src/mdbr_merge.sv -----
// Merges the lane results into one output item, with a skid stage toward the sink.
`timescale 1ns / 1ps

module mdbr_merge
    import mdbr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [MAX_CHANNELS-1:0] i_debounced,
    input  logic [MAX_CHANNELS-1:0] i_logic,
    output logic                    o_ready,
    output logic                    o_valid,
    input  logic                    i_take_ready,
    output logic [2*MAX_CHANNELS-1:0] o_data
);

    logic [2*MAX_CHANNELS-1:0] r_out, r_skid;
    logic                      r_out_valid, r_skid_valid;
    logic                      take;
    logic [2*MAX_CHANNELS-1:0] new_item;

    assign new_item = {i_logic, i_debounced};
    assign take     = r_out_valid && i_take_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_accept) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_accept) begin
            if (r_out_valid && !take) begin
                r_skid <= new_item;
            end else begin
                r_out <= new_item;
            end
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid) else $error("skid entry without output entry");
    a_fill_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_out_valid && !i_take_ready) |=> r_skid_valid)
        else $error("held result not parked in skid stage");
    a_drain_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_take_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid stage not drained on transfer");

endmodule

// ----- src/multi_input_debounce_with_release_delay_unit.sv -----
// Top level of the multi-input debounce unit with release delay.
`timescale 1ns / 1ps

// Debounces up to 16 active-low inputs, one lane per channel working in parallel.
// Each input transfer is a fast sample tick (tuser 0, raw levels in tdata) or a
// slow release tick (tuser 1, tdata ignored), and yields exactly one output
// transfer with the debounced and logic masks after that tick. The lanes work on
// an item within the cycle of its input transfer, and the merged result is
// registered at that edge in the output or skid stage and offered from there. A new item
// is taken every cycle; a two-entry output stage keeps the input ready while one
// result waits on the sink, and the input stalls only once two results wait.
// Configuration writes take effect on the next item and are to be made while no
// results are outstanding. Channels at or above CHANNELS read as zero.
module multi_input_debounce_with_release_delay_unit
    import mdbr_pkg::*;
#(
    parameter int unsigned CHANNELS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] raw_inputs
    input  logic                  s_tuser,   // [0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [15:0] debounced_bits, [31:16] logic_bits
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [COUNT_W-1:0]    r_limit;
    logic [CFG_DATA_W-1:0] r_delay_lo, r_delay_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_delay_lo <= '0;
            r_delay_hi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEBOUNCE_LIMIT: r_limit    <= i_cfg_wdata[COUNT_W-1:0];
                CFG_DELAY_LOW:      r_delay_lo <= i_cfg_wdata;
                CFG_DELAY_HIGH:     r_delay_hi <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic       accept;
    t_lane_ctrl lane_ctrl;
    logic [MAX_CHANNELS-1:0] deb_next, logic_next;

    assign accept          = s_tvalid && s_tready;
    assign lane_ctrl.step  = accept;
    assign lane_ctrl.slow  = (s_tuser == ACTION_SLOW);
    // A limit of zero behaves as one.
    assign lane_ctrl.limit = (r_limit == '0) ? COUNT_W'(1) : r_limit;

    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
        if (c < CHANNELS) begin : g_used
            logic [DELAY_W-1:0] delay;
            if (c < 8) begin : g_lo
                assign delay = r_delay_lo[DELAY_W*c +: DELAY_W];
            end else begin : g_hi
                assign delay = r_delay_hi[DELAY_W*(c-8) +: DELAY_W];
            end
            mdbr_lane u_lane (
                .i_clk            (i_clk),
                .i_rst_n          (i_rst_n),
                .i_ctrl           (lane_ctrl),
                .i_raw            (s_tdata[c]),
                .i_load           (f_release_load(delay)),
                .o_debounced_next (deb_next[c]),
                .o_logic_next     (logic_next[c])
            );
        end else begin : g_unused
            assign deb_next[c]   = 1'b0;
            assign logic_next[c] = 1'b0;
        end
    end

    mdbr_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_debounced  (deb_next),
        .i_logic      (logic_next),
        .o_ready      (s_tready),
        .o_valid      (m_tvalid),
        .i_take_ready (m_tready),
        .o_data       (m_tdata)
    );

endmodule
